// ===== rtl/zcst_pkg.sv =====
// Shared widths, constants and register codes of the zero-cross square tremolo.
package zcst_pkg;

  localparam int unsigned SAMPLE_W = 24;
  localparam int unsigned PHASE_W  = 32;
  localparam int unsigned WET_W    = 17;
  localparam int unsigned FRAME_W  = 2 * SAMPLE_W;
  localparam int unsigned ADDR_W   = 3;
  localparam int unsigned DATA_W   = 32;

  localparam logic [PHASE_W:0]   PHASE_ONE = 33'h0_8000_0000;
  localparam logic [WET_W-1:0]   WET_ONE   = 17'h1_0000;

  typedef enum logic {
    REG_PHASE_INC = 1'b0,
    REG_WET_MIX   = 1'b1
  } reg_idx_t;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

endpackage

// ===== rtl/zero_cross_square_tremolo.sv =====
// Top level of the zero-cross square tremolo: phase accumulator, gates, mix, output register.
// Each input transfer loads its result directly into the output register.
// Throughput: one stereo frame per cycle; a new frame is taken while the output register
//   is empty or its result is transferred in the same cycle.
// The path from the input port to the output register holds one 33-bit add and compare
//   and one 18x24 multiplier per channel.
// Reset (rst_n, synchronous, active low): phase, sign and gate state clear, output empty,
//   phase_increment = 0, wet_mix = 65536.
module zero_cross_square_tremolo
  import zcst_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // input frame stream
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [FRAME_W-1:0]   in_tdata,   // [23:0] sample_left, [47:24] sample_right
  // result frame stream
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [FRAME_W-1:0]   out_tdata,  // [23:0] out_left, [47:24] out_right
  // configuration port
  input  logic                 cfg_psel,
  input  logic                 cfg_penable,
  input  logic                 cfg_pwrite,
  input  logic [ADDR_W-1:0]    cfg_paddr,
  input  logic [DATA_W-1:0]    cfg_pwdata,
  output logic [DATA_W-1:0]    cfg_prdata,
  output logic                 cfg_pready
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [PHASE_W-1:0] phase_inc_r;
  logic [WET_W-1:0]   wet_mix_r;
  reg_idx_t           cfg_idx;
  logic               cfg_wr;

  // Registers lie at byte addresses 0 and 4; decode on the word bit only.
  assign cfg_idx    = reg_idx_t'(cfg_paddr[2]);
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_inc_r <= '0;
      wet_mix_r   <= WET_ONE;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_PHASE_INC: phase_inc_r <= cfg_pwdata;
        REG_WET_MIX:   wet_mix_r   <= cfg_pwdata[WET_W-1:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_PHASE_INC: cfg_prdata = phase_inc_r;
      REG_WET_MIX:   cfg_prdata = {{(DATA_W-WET_W){1'b0}}, wet_mix_r};
      default:       cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Handshake: the output register parts the two sides
  // ---------------------------------------------------------------------------
  logic in_xfer;
  logic out_valid_r;

  assign in_tready  = !out_valid_r || out_tready;
  assign in_xfer    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;

  // ---------------------------------------------------------------------------
  // Phase accumulator: a sum above one returns the phase to zero
  // ---------------------------------------------------------------------------
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [PHASE_W:0]   phase_sum;
  logic               below_half;

  assign phase_sum  = {1'b0, phase_r} + {1'b0, phase_inc_r};
  assign phase_nxt  = (phase_sum > PHASE_ONE) ? '0 : phase_sum[PHASE_W-1:0];
  // Exactly one half does not mute.
  assign below_half = (phase_nxt[PHASE_W-1:PHASE_W-2] == 2'b00);

  // ---------------------------------------------------------------------------
  // Zero-crossing gates: latch mute at each change of sign (zero is positive)
  // ---------------------------------------------------------------------------
  sample_t smp_l, smp_r;
  logic    sign_l_r, sign_r_r, sign_l_nxt, sign_r_nxt;
  logic    gate_l_r, gate_r_r, gate_l_nxt, gate_r_nxt;

  assign smp_l      = in_tdata[SAMPLE_W-1:0];
  assign smp_r      = in_tdata[FRAME_W-1:SAMPLE_W];
  assign sign_l_nxt = !smp_l[SAMPLE_W-1];
  assign sign_r_nxt = !smp_r[SAMPLE_W-1];
  assign gate_l_nxt = (sign_l_nxt != sign_l_r) ? below_half : gate_l_r;
  assign gate_r_nxt = (sign_r_nxt != sign_r_r) ? below_half : gate_r_r;

  // ---------------------------------------------------------------------------
  // Mix: unmuted gives the dry sample back; muted keeps (1 - wet) of it
  // ---------------------------------------------------------------------------
  logic [WET_W-1:0]            wet_c, dry_w;
  logic signed [WET_W+SAMPLE_W:0] prod_l, prod_r;
  sample_t                     mix_l, mix_r;

  // Clamp the wet weight at one.
  assign wet_c  = (wet_mix_r > WET_ONE) ? WET_ONE : wet_mix_r;
  assign dry_w  = WET_ONE - wet_c;
  // Extend both factors to the full product width before multiplying.
  assign prod_l = $signed({{(SAMPLE_W+1){1'b0}}, dry_w}) *
                  $signed({{(WET_W+1){smp_l[SAMPLE_W-1]}}, smp_l});
  assign prod_r = $signed({{(SAMPLE_W+1){1'b0}}, dry_w}) *
                  $signed({{(WET_W+1){smp_r[SAMPLE_W-1]}}, smp_r});
  // Floor shift by 16; the result stays inside 24 bits.
  assign mix_l  = gate_l_nxt ? prod_l[SAMPLE_W+15:16] : smp_l;
  assign mix_r  = gate_r_nxt ? prod_r[SAMPLE_W+15:16] : smp_r;

  // ---------------------------------------------------------------------------
  // State and output registers
  // ---------------------------------------------------------------------------
  logic [FRAME_W-1:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= '0;
      sign_l_r    <= 1'b0;
      sign_r_r    <= 1'b0;
      gate_l_r    <= 1'b0;
      gate_r_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        // advance the oscillator and latch the gates for this frame
        phase_r  <= phase_nxt;
        sign_l_r <= sign_l_nxt;
        sign_r_r <= sign_r_nxt;
        gate_l_r <= gate_l_nxt;
        gate_r_r <= gate_r_nxt;
      end
      if (in_xfer) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload needs no reset; load only on an input transfer.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_data_r <= {mix_r, mix_l};
    end
  end

  assign out_tdata = out_data_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, phase_r} <= PHASE_ONE)
    else $error("phase above one");

  a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_xfer |=> $stable(phase_r) && $stable(gate_l_r) && $stable(gate_r_r))
    else $error("tremolo state changed without a transfer");

  a_pass_through: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && !gate_l_nxt && !gate_r_nxt |=> out_tdata == $past(in_tdata))
    else $error("unmuted frame not passed through");

  a_full_wet_mute: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && gate_l_nxt && (wet_c == WET_ONE) |=> out_tdata[SAMPLE_W-1:0] == '0)
    else $error("fully wet muted channel not zero");

  a_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |=> out_valid_r && $stable(out_data_r))
    else $error("stalled result lost");

endmodule
